>>> sv/btc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// btc_pkg: shared types and constants for the blank-run-to-tab compressor
// Widths, character codes, register indexes and the item and divider
// request/response types used across the front end, queue and back end.
// ----------------------------------------------------------------------------
package btc_pkg;

    localparam int BYTE_W     = 8;
    localparam int TAB_W      = 6;
    localparam int LINE_W     = 8;
    localparam int PHASE_W    = 5;
    localparam int PEND_W     = 6;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 8;

    localparam logic [CFG_IDX_W-1:0] CFG_TAB_SIZE   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_LINE_START = 1'b1;

    localparam logic [TAB_W-1:0]  TAB_SIZE_RESET = 6'd8;
    localparam logic [TAB_W-1:0]  MAX_TAB_SIZE   = 6'd32;
    localparam logic [LINE_W-1:0] LINE_START_RESET = 8'd0;
    localparam logic [PEND_W:0]   MAX_PENDING    = 7'd48;

    localparam logic [BYTE_W-1:0] CH_TAB     = 8'd9;
    localparam logic [BYTE_W-1:0] CH_NEWLINE = 8'd10;
    localparam logic [BYTE_W-1:0] CH_SPACE   = 8'd32;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // remainder unit: one dividend bit per cycle
    localparam int MOD_STEPS = BYTE_W;
    localparam int MOD_CNT_W = $clog2(MOD_STEPS + 1);

    typedef enum logic [1:0] {
        K_SPACE,
        K_TAB,
        K_NEWLINE,
        K_OTHER
    } t_kind;

    typedef struct packed {
        t_kind             kind;
        logic [BYTE_W-1:0] data;
    } t_item;

    typedef struct packed {
        logic              start;
        logic [BYTE_W-1:0] dividend;
        logic [TAB_W-1:0]  divisor;
    } t_mod_req;

    typedef struct packed {
        logic               done;
        logic [PHASE_W-1:0] rem;
    } t_mod_rsp;

    // zero acts as one, oversize clamps to the maximum
    function automatic logic [TAB_W-1:0] eff_tab(input logic [TAB_W-1:0] t);
        logic [TAB_W-1:0] r;
        r = t;
        if (t == '0) begin
            r = TAB_W'(1);
        end else if (t > MAX_TAB_SIZE) begin
            r = MAX_TAB_SIZE;
        end
        return r;
    endfunction

endpackage
`default_nettype wire

>>> sv/btc_in_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// btc_in_if: input byte channel
// Valid/ready channel carrying one text byte per transaction.
// ----------------------------------------------------------------------------
interface btc_in_if import btc_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] in_byte;

    modport source (output valid, output in_byte, input ready);
    modport sink   (input valid, input in_byte, output ready);
endinterface
`default_nettype wire

>>> sv/btc_out_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// btc_out_if: output byte channel
// Valid/ready channel carrying one emitted byte and its last flag.
// ----------------------------------------------------------------------------
interface btc_out_if import btc_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] out_byte;
    logic              last;

    modport source (output valid, output out_byte, output last, input ready);
    modport sink   (input valid, input out_byte, input last, output ready);
endinterface
`default_nettype wire

>>> sv/btc_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// btc_front: input classifier
// Accepts bytes while the queue has room and tags each as space, tab,
// newline or other before it is queued.
// ----------------------------------------------------------------------------
module btc_front import btc_pkg::*; (
    btc_in_if.sink   i_in,
    input  logic     i_q_full,
    output logic     o_push,
    output t_item    o_item
);

    assign i_in.ready = !i_q_full;
    assign o_push     = i_in.valid && !i_q_full;

    always_comb begin
        o_item.data = i_in.in_byte;
        case (i_in.in_byte)
            CH_SPACE:   o_item.kind = K_SPACE;
            CH_TAB:     o_item.kind = K_TAB;
            CH_NEWLINE: o_item.kind = K_NEWLINE;
            default:    o_item.kind = K_OTHER;
        endcase
    end

endmodule
`default_nettype wire

>>> sv/btc_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// btc_queue: classified item queue
// Short FIFO between the classifier and the back end.
// ----------------------------------------------------------------------------
module btc_queue import btc_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_item i_item,
    output logic  o_full,
    input  logic  i_pop,
    output logic  o_empty,
    output t_item o_item
);

    t_item              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  r_wptr;
    logic [QPTR_W-1:0]  r_rptr;
    logic [QCNT_W-1:0]  r_count;
    logic [QCNT_W-1:0]  n_count;
    logic               do_push;
    logic               do_pop;

    assign o_full  = (r_count == QCNT_W'(QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_item  = r_mem[r_rptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_comb begin
        n_count = r_count;
        if (do_push && !do_pop) begin
            n_count = r_count + QCNT_W'(1);
        end else if (do_pop && !do_push) begin
            n_count = r_count - QCNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_count <= n_count;
            if (do_push) begin
                r_wptr <= (r_wptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wptr + QPTR_W'(1);
            end
            if (do_pop) begin
                r_rptr <= (r_rptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rptr + QPTR_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_item;
        end
    end

endmodule
`default_nettype wire

>>> sv/btc_mod.sv
`default_nettype none
// ----------------------------------------------------------------------------
// btc_mod: iterative remainder unit
// Restoring remainder of an 8-bit value by the tab size, one bit per cycle.
// A new start aborts any calculation in flight.
// ----------------------------------------------------------------------------
module btc_mod import btc_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_mod_req i_req,
    output t_mod_rsp o_rsp
);

    logic                 r_busy;
    logic                 r_done;
    logic [MOD_CNT_W-1:0] r_cnt;
    logic [BYTE_W-1:0]    r_dvd;
    logic [PHASE_W-1:0]   r_rem;
    logic [PHASE_W:0]     trial;
    logic [PHASE_W-1:0]   n_rem;
    logic [TAB_W-1:0]     diff;

    // remainder stays below the divisor (at most 32), so trial fits 6 bits
    assign trial = {r_rem, r_dvd[BYTE_W-1]};
    assign diff  = trial - i_req.divisor;
    assign n_rem = (trial >= i_req.divisor) ? diff[PHASE_W-1:0] : trial[PHASE_W-1:0];

    assign o_rsp.done = r_done;
    assign o_rsp.rem  = r_rem;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= MOD_CNT_W'(MOD_STEPS);
            end else if (r_busy) begin
                r_cnt <= r_cnt - MOD_CNT_W'(1);
                if (r_cnt == MOD_CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_dvd <= i_req.dividend;
            r_rem <= '0;
        end else if (r_busy) begin
            r_dvd <= {r_dvd[BYTE_W-2:0], 1'b0};
            r_rem <= n_rem;
        end
    end

endmodule
`default_nettype wire

>>> sv/btc_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// btc_back: run tracker and byte emitter
// Holds the configuration, column phase and pending blank run; absorbs
// blanks, sends runs as tabs and spaces one byte per cycle unless stalled, and
// passes other bytes through. Reduces the stored phases after a config write.
// ----------------------------------------------------------------------------
module btc_back import btc_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_q_empty,
    input  t_item                 i_item,
    output logic                  o_pop,
    output t_mod_req              o_mod_req,
    input  t_mod_rsp              i_mod_rsp,
    btc_out_if.source             o_out
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_RUN,
        S_BYTE,
        S_NGO,
        S_NWAIT
    } t_state;

    typedef enum logic [1:0] {
        NS_PHASE,
        NS_RUNEND,
        NS_LINE
    } t_nstep;

    t_state              r_state,      n_state;
    t_nstep              r_nstep,      n_nstep;
    logic                r_norm_pend,  n_norm_pend;
    logic [TAB_W-1:0]    r_stop_gap;
    logic [LINE_W-1:0]   r_line_start;
    logic [PHASE_W-1:0]  r_phase,      n_phase;     // raw column phase
    logic [PHASE_W-1:0]  r_pn,         n_pn;        // phase mod tab size
    logic [PHASE_W-1:0]  r_rphase,     n_rphase;    // phase at end of pending run
    logic [PHASE_W-1:0]  r_linep,      n_linep;     // start column mod tab size
    logic [PEND_W-1:0]   r_pending,    n_pending;
    logic [PEND_W-1:0]   r_add,        n_add;
    logic                r_flush_blank, n_flush_blank;
    logic [BYTE_W-1:0]   r_byte,       n_byte;
    logic                r_out_valid,  n_out_valid;
    logic [BYTE_W-1:0]   r_out_byte,   n_out_byte;
    logic                r_out_last,   n_out_last;

    logic [TAB_W-1:0]    t_eff;
    logic                slot_free;
    logic [TAB_W-1:0]    pn_inc;
    logic [PHASE_W-1:0]  pn_wrap;
    logic [TAB_W-1:0]    to_stop;
    logic                tab_step;
    logic [PEND_W-1:0]   step_dec;
    logic [PEND_W-1:0]   pend_left;
    logic [PHASE_W-1:0]  run_phase;
    logic [TAB_W-1:0]    rp_inc;
    logic [PHASE_W-1:0]  blank_rphase;
    logic [PEND_W-1:0]   blank_add;
    logic [PEND_W:0]     pend_sum;
    logic [PEND_W:0]     runend_sum;
    logic [PHASE_W-1:0]  byte_phase;

    assign t_eff     = eff_tab(r_stop_gap);
    assign slot_free = !r_out_valid || o_out.ready;

    assign o_out.valid    = r_out_valid;
    assign o_out.out_byte = r_out_byte;
    assign o_out.last     = r_out_last;

    always_comb begin
        pn_inc     = {1'b0, r_pn} + TAB_W'(1);
        pn_wrap    = (pn_inc == t_eff) ? '0 : pn_inc[PHASE_W-1:0];
        to_stop    = t_eff - {1'b0, r_pn};
        // a tab goes out whenever the rest of the run reaches the next stop
        tab_step   = (r_pending >= to_stop);
        step_dec   = tab_step ? to_stop : PEND_W'(1);
        pend_left  = r_pending - step_dec;
        run_phase  = tab_step ? '0 : pn_inc[PHASE_W-1:0];
        byte_phase = (r_byte == CH_NEWLINE) ? r_linep : pn_wrap;

        rp_inc = {1'b0, r_rphase} + TAB_W'(1);
        if (i_item.kind == K_TAB) begin
            blank_add    = t_eff - {1'b0, r_rphase};
            blank_rphase = '0;
        end else begin
            blank_add    = PEND_W'(1);
            blank_rphase = (rp_inc == t_eff) ? '0 : rp_inc[PHASE_W-1:0];
        end
        pend_sum   = {1'b0, r_pending} + {1'b0, blank_add};
        runend_sum = {{(PEND_W + 1 - PHASE_W){1'b0}}, r_pn} + {1'b0, r_pending};
    end

    always_comb begin
        n_state       = r_state;
        n_nstep       = r_nstep;
        n_norm_pend   = r_norm_pend;
        n_phase       = r_phase;
        n_pn          = r_pn;
        n_rphase      = r_rphase;
        n_linep       = r_linep;
        n_pending     = r_pending;
        n_add         = r_add;
        n_flush_blank = r_flush_blank;
        n_byte        = r_byte;
        n_out_valid   = r_out_valid && !o_out.ready;
        n_out_byte    = r_out_byte;
        n_out_last    = r_out_last;
        o_pop              = 1'b0;
        o_mod_req.start    = 1'b0;
        o_mod_req.dividend = '0;
        o_mod_req.divisor  = t_eff;

        case (r_state)
            S_IDLE: begin
                if (i_cfg_we || r_norm_pend) begin
                    n_state     = S_NGO;
                    n_nstep     = NS_PHASE;
                    n_norm_pend = 1'b0;
                end else if (!i_q_empty) begin
                    o_pop  = 1'b1;
                    n_byte = i_item.data;
                    if (i_item.kind inside {K_SPACE, K_TAB}) begin
                        n_rphase = blank_rphase;
                        if (pend_sum > MAX_PENDING) begin
                            n_add         = blank_add;
                            n_flush_blank = 1'b1;
                            n_state       = S_RUN;
                        end else begin
                            n_pending = pend_sum[PEND_W-1:0];
                        end
                    end else begin
                        n_flush_blank = 1'b0;
                        n_state       = (r_pending == '0) ? S_BYTE : S_RUN;
                    end
                end
            end
            S_RUN: begin
                if (slot_free) begin
                    n_out_valid = 1'b1;
                    n_out_byte  = tab_step ? CH_TAB : CH_SPACE;
                    n_out_last  = r_flush_blank && (pend_left == '0);
                    n_pending   = pend_left;
                    n_pn        = run_phase;
                    if (pend_left == '0) begin
                        n_phase = run_phase;
                        if (r_flush_blank) begin
                            n_pending = r_add;
                            n_state   = S_IDLE;
                        end else begin
                            n_state = S_BYTE;
                        end
                    end
                end
            end
            S_BYTE: begin
                if (slot_free) begin
                    n_out_valid = 1'b1;
                    n_out_byte  = r_byte;
                    n_out_last  = 1'b1;
                    n_phase     = byte_phase;
                    n_pn        = byte_phase;
                    n_rphase    = byte_phase;
                    n_state     = S_IDLE;
                end
            end
            S_NGO: begin
                o_mod_req.start = 1'b1;
                case (r_nstep)
                    NS_PHASE:  o_mod_req.dividend = BYTE_W'(r_phase);
                    NS_RUNEND: o_mod_req.dividend = BYTE_W'(runend_sum);
                    NS_LINE:   o_mod_req.dividend = r_line_start;
                    default:   o_mod_req.dividend = '0;
                endcase
                n_state = S_NWAIT;
                if (i_cfg_we) begin
                    n_state = S_NGO;
                    n_nstep = NS_PHASE;
                end
            end
            S_NWAIT: begin
                if (i_cfg_we) begin
                    n_state = S_NGO;
                    n_nstep = NS_PHASE;
                end else if (i_mod_rsp.done) begin
                    case (r_nstep)
                        NS_PHASE: begin
                            n_pn    = i_mod_rsp.rem;
                            n_nstep = NS_RUNEND;
                            n_state = S_NGO;
                        end
                        NS_RUNEND: begin
                            n_rphase = i_mod_rsp.rem;
                            n_nstep  = NS_LINE;
                            n_state  = S_NGO;
                        end
                        default: begin
                            n_linep = i_mod_rsp.rem;
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end
            default: n_state = S_IDLE;
        endcase

        // writes during run or byte output are reduced once the current transaction ends
        if (i_cfg_we && (r_state inside {S_RUN, S_BYTE})) begin
            n_norm_pend = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_nstep       <= NS_PHASE;
            r_norm_pend   <= 1'b0;
            r_stop_gap    <= TAB_SIZE_RESET;
            r_line_start  <= LINE_START_RESET;
            r_phase       <= '0;
            r_pn          <= '0;
            r_rphase      <= '0;
            r_linep       <= '0;
            r_pending     <= '0;
            r_add         <= '0;
            r_flush_blank <= 1'b0;
            r_byte        <= '0;
            r_out_valid   <= 1'b0;
            r_out_byte    <= '0;
            r_out_last    <= 1'b0;
        end else begin
            r_state       <= n_state;
            r_nstep       <= n_nstep;
            r_norm_pend   <= n_norm_pend;
            r_phase       <= n_phase;
            r_pn          <= n_pn;
            r_rphase      <= n_rphase;
            r_linep       <= n_linep;
            r_pending     <= n_pending;
            r_add         <= n_add;
            r_flush_blank <= n_flush_blank;
            r_byte        <= n_byte;
            r_out_valid   <= n_out_valid;
            r_out_byte    <= n_out_byte;
            r_out_last    <= n_out_last;
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_TAB_SIZE:   r_stop_gap   <= i_cfg_data[TAB_W-1:0];
                    CFG_LINE_START: r_line_start <= i_cfg_data[LINE_W-1:0];
                    default: ;
                endcase
            end
        end
    end

endmodule
`default_nettype wire

>>> sv/blank_run_to_tab_compressor_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// blank_run_to_tab_compressor_unit: blank run to tab compressor
// Text byte stream in, entabbed byte stream out; classifier, item queue,
// run tracker/emitter and a remainder unit.
// ----------------------------------------------------------------------------
// Spaces and tabs are absorbed into a pending run of blank columns and
// produce nothing until a non-blank byte (or a run about to exceed 48
// columns) sends the run as tabs and spaces; each emitted byte carries last
// on the final byte caused by its input transaction. The emitter writes one
// byte per cycle into an output register while the receiver accepts; a
// pass-through byte is dequeued and then emitted, an absorbed blank is
// only dequeued, and a run goes out one output byte at a time. The front
// end keeps accepting into a two-entry queue while the back end works.
// After any configuration write the back end reduces its column phases by
// the new tab size (three passes of the remainder unit) before it takes
// the next queued byte.
module blank_run_to_tab_compressor_unit import btc_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    btc_in_if.sink                i_in,
    btc_out_if.source             o_out
);

    logic     q_full;
    logic     q_empty;
    logic     push;
    logic     pop;
    t_item    push_item;
    t_item    head_item;
    t_mod_req mod_req;
    t_mod_rsp mod_rsp;

    btc_front u_front (
        .i_in     (i_in),
        .i_q_full (q_full),
        .o_push   (push),
        .o_item   (push_item)
    );

    btc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (push_item),
        .o_full  (q_full),
        .i_pop   (pop),
        .o_empty (q_empty),
        .o_item  (head_item)
    );

    btc_mod u_mod (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (mod_req),
        .o_rsp   (mod_rsp)
    );

    btc_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_q_empty   (q_empty),
        .i_item      (head_item),
        .o_pop       (pop),
        .o_mod_req   (mod_req),
        .i_mod_rsp   (mod_rsp),
        .o_out       (o_out)
    );

endmodule
`default_nettype wire

>>> verif/entab_monitor.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// entab_monitor: output check for the blank-run-to-tab compressor
// Watches the config port and both byte channels, runs its own entab model
// on every accepted input byte and compares each emitted byte and last flag,
// in order, with the bytes the model says are due.
// ----------------------------------------------------------------------------
module entab_monitor import btc_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    btc_in_if                     i_text,
    btc_out_if                    i_emit,
    output int                    o_fail_count,
    output int                    o_outstanding
);

    typedef struct packed {
        logic [BYTE_W-1:0] out_byte;
        logic              last;
    } t_emitted;

    logic [TAB_W-1:0]   stop_gap;
    logic [LINE_W-1:0]  line_start;
    logic [PHASE_W-1:0] col_phase;
    logic [PEND_W-1:0]  blank_run;
    t_emitted           due_bytes[$];
    int                 errors;

    initial begin
        errors = 0;
    end

    // zero spacing behaves as one, anything past the maximum clamps
    function automatic int stop_spacing(input logic [TAB_W-1:0] t);
        if (t == '0) return 1;
        if (int'(t) > int'(MAX_TAB_SIZE)) return int'(MAX_TAB_SIZE);
        return int'(t);
    endfunction

    task automatic queue_byte(input logic [BYTE_W-1:0] b);
        t_emitted e;
        e.out_byte = b;
        e.last     = 1'b0;
        due_bytes.push_back(e);
    endtask

    // send the pending blank run: leading tab if it reaches the stop,
    // then whole tabs, then spaces
    task automatic flush_blanks(input int t);
        int p;
        int first;
        int rest;
        p     = int'(col_phase) % t;
        first = t - p;
        if (int'(blank_run) < first) begin
            repeat (int'(blank_run)) queue_byte(CH_SPACE);
            col_phase = PHASE_W'((p + int'(blank_run)) % t);
        end else begin
            rest = int'(blank_run) - first;
            queue_byte(CH_TAB);
            repeat (rest / t) queue_byte(CH_TAB);
            repeat (rest % t) queue_byte(CH_SPACE);
            col_phase = PHASE_W'(rest % t);
        end
        blank_run = '0;
    endtask

    task automatic entab_step(input logic [BYTE_W-1:0] c);
        int t;
        int add;
        int queued0;
        t       = stop_spacing(stop_gap);
        queued0 = due_bytes.size();
        if (c == CH_TAB || c == CH_SPACE) begin
            if (c == CH_SPACE) begin
                add = 1;
            end else begin
                add = t - ((int'(col_phase) % t + int'(blank_run)) % t);
            end
            if (int'(blank_run) + add > int'(MAX_PENDING)) begin
                flush_blanks(t);
            end
            blank_run = PEND_W'(int'(blank_run) + add);
        end else begin
            flush_blanks(t);
            queue_byte(c);
            if (c == CH_NEWLINE) begin
                col_phase = PHASE_W'(int'(line_start) % t);
            end else begin
                col_phase = PHASE_W'((int'(col_phase) % t + 1) % t);
            end
        end
        if (due_bytes.size() > queued0) begin
            due_bytes[due_bytes.size() - 1].last = 1'b1;
        end
    endtask

    always @(posedge i_clk) begin
        t_emitted oldest;
        if (!i_rst_n) begin
            stop_gap   = TAB_SIZE_RESET;
            line_start = LINE_START_RESET;
            col_phase  = '0;
            blank_run  = '0;
            due_bytes.delete();
        end else begin
            // outputs first: a byte accepted now can only belong to older input
            if (i_emit.valid && i_emit.ready) begin
                if (due_bytes.size() == 0) begin
                    if (errors < 10) begin
                        $display("entab_monitor: unexpected byte %h last %b",
                                 i_emit.out_byte, i_emit.last);
                    end
                    errors++;
                end else begin
                    oldest = due_bytes.pop_front();
                    if (oldest.out_byte !== i_emit.out_byte || oldest.last !== i_emit.last)
                    begin
                        if (errors < 10) begin
                            $display("entab_monitor: byte exp %h got %h, last exp %b got %b",
                                     oldest.out_byte, i_emit.out_byte,
                                     oldest.last, i_emit.last);
                        end
                        errors++;
                    end
                end
            end
            if (i_cfg_we) begin
                if (i_cfg_index == CFG_TAB_SIZE) begin
                    stop_gap = i_cfg_data[TAB_W-1:0];
                end else if (i_cfg_index == CFG_LINE_START) begin
                    line_start = i_cfg_data[LINE_W-1:0];
                end
            end
            if (i_text.valid && i_text.ready) begin
                entab_step(i_text.in_byte);
            end
        end
        o_fail_count  <= errors;
        o_outstanding <= due_bytes.size();
    end

endmodule
`default_nettype wire

>>> verif/testbench.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// testbench: blank-run-to-tab compressor
// Directed text covering byte extremes, tab stops, start columns past a stop,
// zero and oversized tab sizes, a size change mid-line and run overflow, then
// random text under several tab size / start column settings. Both channels
// stall at random; the receiver also holds off once for a long stretch.
// ----------------------------------------------------------------------------
module testbench;
    import btc_pkg::*;

    localparam int CYCLE_LIMIT   = 500000;
    localparam int SETTLE_CYCLES = 64;
    localparam int PHASE_ITEMS   = 57;
    localparam int N_PHASES      = 8;
    localparam int HOLD_AT       = 150;
    localparam int HOLD_CYCLES   = 400;
    localparam int CALM_FROM     = 300;
    localparam int CALM_TO       = 400;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    int                    fail_count;
    int                    outstanding;
    int                    cycle_count = 0;
    int                    items_sent  = 0;
    logic                  calm_stretch;
    logic [BYTE_W-1:0]     script[$];

    // tab size data deliberately includes values with the upper data bits set
    logic [CFG_DATA_W-1:0] tab_plan  [N_PHASES] = '{8'd1, 8'd32, 8'd8, 8'hC3,
                                                    8'd0, 8'd63, 8'd2, 8'd0};
    logic [CFG_DATA_W-1:0] line_plan [N_PHASES] = '{8'd0, 8'd255, 8'd0, 8'd17,
                                                    8'd255, 8'd100, 8'd1, 8'd0};

    btc_in_if  text_in();
    btc_out_if text_out();

    blank_run_to_tab_compressor_unit i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .i_in        (text_in),
        .o_out       (text_out)
    );

    entab_monitor entab_check (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (cfg_we),
        .i_cfg_index   (cfg_index),
        .i_cfg_data    (cfg_data),
        .i_text        (text_in),
        .i_emit        (text_out),
        .o_fail_count  (fail_count),
        .o_outstanding (outstanding)
    );

    assign calm_stretch = (items_sent >= CALM_FROM) && (items_sent < CALM_TO);

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("testbench: FAIL");
            $finish;
        end
    end

    // receiver: random stalls, one long hold-off, and a stall-free stretch
    initial begin : receiver
        int   hold_left;
        logic hold_used;
        hold_left = 0;
        hold_used = 1'b0;
        text_out.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_left > 0) begin
                hold_left--;
                text_out.ready <= 1'b0;
            end else if (!hold_used && items_sent >= HOLD_AT) begin
                hold_used = 1'b1;
                hold_left = HOLD_CYCLES;
                text_out.ready <= 1'b0;
            end else if (calm_stretch) begin
                text_out.ready <= 1'b1;
            end else begin
                text_out.ready <= ($urandom_range(99) >= 22);
            end
        end
    end

    task automatic send_item(input logic [BYTE_W-1:0] b);
        while (!calm_stretch && $urandom_range(99) < 22) begin
            text_in.valid <= 1'b0;
            @(posedge i_clk);
        end
        text_in.valid   <= 1'b1;
        text_in.in_byte <= b;
        do @(posedge i_clk); while (!text_in.ready);
        items_sent <= items_sent + 1;
    endtask

    task automatic play_script();
        foreach (script[k]) send_item(script[k]);
        script.delete();
    endtask

    // wait out every due byte, then the back end's remaining work
    task automatic settle();
        text_in.valid <= 1'b0;
        @(posedge i_clk);
        while (outstanding != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic load_config(input logic [CFG_DATA_W-1:0] tab_data,
                               input logic [CFG_DATA_W-1:0] line_data);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_TAB_SIZE;
        cfg_data  <= tab_data;
        @(posedge i_clk);
        cfg_index <= CFG_LINE_START;
        cfg_data  <= line_data;
        @(posedge i_clk);
        cfg_we    <= 1'b0;
    endtask

    // mostly text-like: blanks, printable characters, newlines, some raw bytes
    function automatic logic [BYTE_W-1:0] pick_char();
        int r;
        r = $urandom_range(99);
        if (r < 34) return CH_SPACE;
        if (r < 50) return CH_TAB;
        if (r < 58) return CH_NEWLINE;
        if (r < 88) return BYTE_W'($urandom_range(126, 33));
        return BYTE_W'($urandom_range(255));
    endfunction

    initial begin : stimulus
        int sent;
        int n;
        i_rst_n         <= 1'b0;
        cfg_we          <= 1'b0;
        cfg_index       <= CFG_TAB_SIZE;
        cfg_data        <= '0;
        text_in.valid   <= 1'b0;
        text_in.in_byte <= '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset settings: byte extremes, tab inside a run, trailing blanks
        script = '{8'h41, CH_TAB, CH_SPACE, 8'h42, 8'h00, 8'hFF, CH_SPACE, CH_NEWLINE};
        play_script();
        settle();

        // spacing 32, start column one short of a stop; third tab overflows the run
        load_config(8'hFF, 8'd255);
        script = '{CH_NEWLINE, CH_TAB, CH_TAB, CH_TAB, 8'h78};
        play_script();
        settle();

        load_config(8'd0, 8'd3);
        script = '{CH_SPACE, CH_TAB, 8'h63, CH_NEWLINE};
        play_script();
        settle();

        load_config(8'd13, 8'd200);
        script = '{CH_NEWLINE, 8'h65, 8'h66, CH_SPACE};
        play_script();
        settle();

        // shrink the spacing with a blank still pending mid-line
        load_config(8'd5, 8'd200);
        script = '{CH_TAB, 8'h67};
        play_script();
        settle();

        for (int ph = 0; ph < N_PHASES; ph++) begin
            if (ph == N_PHASES - 1) begin
                load_config(CFG_DATA_W'($urandom_range(32, 1)), CFG_DATA_W'($urandom_range(255)));
            end else begin
                load_config(tab_plan[ph], line_plan[ph]);
            end
            sent = 0;
            while (sent < PHASE_ITEMS) begin
                if ($urandom_range(99) < 5) begin
                    // long space runs can push the pending count over its limit
                    n = $urandom_range(60, 20);
                    if (n > PHASE_ITEMS - sent) n = PHASE_ITEMS - sent;
                    repeat (n) send_item(CH_SPACE);
                    sent += n;
                end else begin
                    send_item(pick_char());
                    sent++;
                end
            end
            settle();
        end

        if (fail_count == 0) begin
            $display("testbench: PASS");
        end else begin
            $display("testbench: FAIL");
        end
        $finish;
    end

endmodule
`default_nettype wire
